// ===== hw/rtl/stack_machine_execute_unit_core_assert.svh =====
// Assertion macros shared by the execute unit RTL.
`ifndef STACK_MACHINE_EXECUTE_UNIT_CORE_ASSERT_SVH
`define STACK_MACHINE_EXECUTE_UNIT_CORE_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define SMX_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define SMX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/smx_pkg.sv =====
`timescale 1ns / 1ps

package smx_pkg;

    localparam int OP_W = 5;
    localparam int WORD_W = 32;
    localparam int IDX_W = 10;
    localparam int NEXT_W = 11;

    // Program positions are 10 bits and branch targets are truncated to 11 bits,
    // so the program length is fixed by those widths.
    localparam int PROGRAM_LENGTH = 1024;

    typedef enum logic [4:0] {
        OP_PUSH = 5'd0, OP_ADD = 5'd1, OP_SUB = 5'd2, OP_MUL = 5'd3, OP_DIV = 5'd4,
        OP_OUTC = 5'd5, OP_OUTV = 5'd6, OP_GETC = 5'd7, OP_SWAP = 5'd8,
        OP_CALL = 5'd9, OP_CALLZ = 5'd10, OP_CALLNZ = 5'd11, OP_GOTO = 5'd12,
        OP_GOTOZ = 5'd13, OP_GOTONZ = 5'd14, OP_RET = 5'd15, OP_HALT = 5'd16,
        OP_DUP = 5'd17, OP_DROP = 5'd18, OP_EQ = 5'd19, OP_GT = 5'd20,
        OP_LT = 5'd21, OP_GE = 5'd22, OP_LE = 5'd23, OP_SYSEXIT = 5'd24,
        OP_NOP = 5'd25
    } op_t;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_UNDER = 3'd1, ST_OVER = 3'd2, ST_DIVZ = 3'd3,
        ST_RETEMPTY = 3'd4, ST_UNKNOWN = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0, KIND_CHAR = 2'd1, KIND_VALUE = 2'd2
    } kind_t;

    // Handshake between the sequencer and the divider.
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;

endpackage

// ===== hw/rtl/smx_ram.sv =====
`timescale 1ns / 1ps

module smx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/smx_div.sv =====
`timescale 1ns / 1ps

// Signed restoring divider, one quotient bit per cycle, truncating toward zero.
module smx_div (
    input  logic              clk,
    input  logic              rst_n,
    input  smx_pkg::div_req_t req,
    output smx_pkg::div_rsp_t rsp
);
    import smx_pkg::*;

    logic        busy_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] quo_reg;
    logic [32:0] rem_reg;
    logic [31:0] dvs_reg;
    logic        neg_reg;
    logic        done_reg;
    logic [32:0] trial;
    logic [32:0] shifted;

    assign shifted = {rem_reg[31:0], quo_reg[31]};
    assign trial = shifted - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= 6'd32;
                quo_reg <= req.dividend[31] ? (32'd0 - req.dividend) : req.dividend;
                dvs_reg <= req.divisor[31] ? (32'd0 - req.divisor) : req.divisor;
                neg_reg <= req.dividend[31] ^ req.divisor[31];
                rem_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (!trial[32])
                begin
                    rem_reg <= trial;
                    quo_reg <= {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg <= shifted;
                    quo_reg <= {quo_reg[30:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quotient = neg_reg ? (32'd0 - quo_reg) : quo_reg;

endmodule

// ===== hw/rtl/stack_machine_execute_unit_core.sv =====
`timescale 1ns / 1ps
// An instruction goes from S_IDLE through S_RD1 (top read), S_EXEC (second read,
// execute and write back) and, for div, S_DIV to S_OUT; once stopped, S_IDLE goes to S_OUT.
// One instruction at a time: a new input is taken only in S_IDLE, after the last result
// beat; the two reads from the single-read-port data stack memory, the result register
// and the idle state after each result beat set this pace.
// Reset clears stack depths, the halted flag, the exit code and config; memories are not cleared.
module stack_machine_execute_unit_core #(
    parameter int STACK_DEPTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [4:0]  operation,
    input  logic signed [31:0] operand,
    input  logic [9:0]  instr_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [10:0] next_index,
    output logic [1:0]  out_kind,
    output logic signed [31:0] out_data,
    output logic [2:0]  status,
    output logic        stopped,
    output logic signed [31:0] exit_code
);
    import smx_pkg::*;
    `include "stack_machine_execute_unit_core_assert.svh"

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_RD1, S_EXEC, S_DIV, S_OUT
    } state_t;

    state_t      state_reg;
    logic [4:0]  op_reg;
    logic [31:0] imm_reg;
    logic [9:0]  idx_reg;
    logic [DW-1:0] dd_reg;
    logic [DW-1:0] rd_reg;
    logic        halted_reg;
    logic        coe_reg;
    logic [31:0] code_reg;
    logic [31:0] top_reg;
    logic [31:0] a_reg;

    // Result registers.
    logic [10:0] r_next_reg;
    logic [1:0]  r_kind_reg;
    logic [31:0] r_data_reg;
    logic [2:0]  r_status_reg;
    logic        r_stop_reg;
    logic [31:0] r_code_reg;

    // Data stack memory.
    logic          d_we;
    logic [AW-1:0] d_waddr;
    logic [31:0]   d_wdata;
    logic [AW-1:0] d_raddr;
    logic [31:0]   d_rdata;

    // Return stack memory.
    logic          r_we;
    logic [AW-1:0] r_waddr;
    logic [10:0]   r_wdata;
    logic [AW-1:0] r_raddr;
    logic [10:0]   r_rdata;

    div_req_t div_req;
    div_rsp_t div_rsp;

    smx_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_dstack (
        .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
        .raddr(d_raddr), .rdata(d_rdata)
    );

    smx_ram #(.WIDTH(11), .DEPTH(STACK_DEPTH)) u_rstack (
        .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
        .raddr(r_raddr), .rdata(r_rdata)
    );

    smx_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

    logic in_beat;
    logic out_beat;
    assign in_beat = in_valid && in_ready;
    assign out_beat = out_valid && out_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    // Read addresses: top at depth-1 first, then second at depth-2.
    logic [DW-1:0] dm1;
    logic [DW-1:0] dm2;
    logic [DW-1:0] rm1;
    assign dm1 = dd_reg - DW'(1);
    assign dm2 = dd_reg - DW'(2);
    assign rm1 = rd_reg - DW'(1);
    assign d_raddr = (state_reg == S_IDLE) ? dm1[AW-1:0] : dm2[AW-1:0];
    assign r_raddr = rm1[AW-1:0];

    // Execute-stage combinational work; operands are top (b) and second (a).
    logic [31:0] b_v;
    logic [31:0] a_v;
    logic        has1;
    logic        has2;
    logic        full;
    assign has1 = dd_reg != '0;
    assign has2 = dd_reg > DW'(1);
    assign full = dd_reg == DW'(STACK_DEPTH);
    assign b_v = has1 ? top_reg : 32'd0;
    assign a_v = has2 ? d_rdata : 32'd0;

    typedef struct packed {
        logic [10:0]   next;
        logic [1:0]    kind;
        logic [31:0]   data;
        logic [2:0]    err;
        logic          stop;
        logic [31:0]   code;
        logic [DW-1:0] dd;
        logic [DW-1:0] rd;
        logic          dwe;
        logic [AW-1:0] dwa;
        logic [31:0]   dwd;
        logic          rwe;
        logic [AW-1:0] rwa;
        logic [10:0]   rwd;
        logic          div;
    } exec_t;

    exec_t ex;
    logic [10:0] idx1;
    logic [10:0] idx2;
    assign idx1 = {1'b0, idx_reg} + 11'd1;
    assign idx2 = {1'b0, idx_reg} + 11'd2;

    // Execute decode: new depths, stack writes, result fields and status for op_reg.
    always_comb
    begin
        logic [DW-1:0] base;
        logic          cmp;
        logic          taken;
        logic          is_cond;
        logic signed [31:0] sa;
        logic signed [31:0] sb;
        ex = '0;
        ex.next = idx1;
        ex.dd = dd_reg;
        ex.rd = rd_reg;
        base = dd_reg;
        cmp = 1'b0;
        taken = 1'b1;
        is_cond = 1'b0;
        sa = a_v;
        sb = b_v;
        case (op_reg)
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_GT, OP_LT, OP_GE, OP_LE:
            begin
                if (!has2)
                begin
                    ex.err = ST_UNDER;
                end
                base = has2 ? dd_reg - DW'(2) : '0;
                case (op_reg)
                    OP_EQ: cmp = sa == sb;
                    OP_GT: cmp = sa > sb;
                    OP_LT: cmp = sa < sb;
                    OP_GE: cmp = sa >= sb;
                    OP_LE: cmp = sa <= sb;
                    default: cmp = 1'b0;
                endcase
                ex.dd = base + DW'(1);
                ex.dwe = 1'b1;
                ex.dwa = base[AW-1:0];
                case (op_reg)
                    OP_ADD: ex.dwd = a_v + b_v;
                    OP_SUB: ex.dwd = a_v - b_v;
                    OP_MUL: ex.dwd = a_v * b_v;
                    OP_DIV: ex.dwd = 32'd0;
                    default: ex.dwd = {31'd0, cmp};
                endcase
                if (op_reg == OP_DIV)
                begin
                    ex.dwe = 1'b0;
                    if (b_v == 32'd0)
                    begin
                        if (ex.err == ST_OK)
                        begin
                            ex.err = ST_DIVZ;
                        end
                        ex.dd = base;
                    end
                    else
                    begin
                        ex.div = 1'b1;
                    end
                end
            end
            OP_PUSH, OP_GETC:
            begin
                if (full)
                begin
                    ex.err = ST_OVER;
                end
                else
                begin
                    ex.dwe = 1'b1;
                    ex.dwa = dd_reg[AW-1:0];
                    ex.dwd = imm_reg;
                    ex.dd = dd_reg + DW'(1);
                end
            end
            OP_DUP:
            begin
                if (!has1)
                begin
                    ex.err = ST_UNDER;
                end
                if (full)
                begin
                    ex.err = ST_OVER;
                end
                else
                begin
                    ex.dwe = 1'b1;
                    ex.dwa = dd_reg[AW-1:0];
                    ex.dwd = b_v;
                    ex.dd = dd_reg + DW'(1);
                end
            end
            OP_OUTC:
            begin
                if (has1)
                begin
                    ex.kind = KIND_CHAR;
                    ex.data = {24'd0, top_reg[7:0]};
                    ex.dd = dd_reg - DW'(1);
                end
                else
                begin
                    ex.err = ST_UNDER;
                end
            end
            OP_OUTV:
            begin
                ex.kind = KIND_VALUE;
                ex.data = b_v;
                if (has1)
                begin
                    ex.dd = dd_reg - DW'(1);
                end
                else
                begin
                    ex.err = ST_UNDER;
                end
            end
            OP_DROP:
            begin
                if (has1)
                begin
                    ex.dd = dd_reg - DW'(1);
                end
                else
                begin
                    ex.err = ST_UNDER;
                end
            end
            OP_SWAP:
            begin
                // With two or more values only the two slots swap; a short
                // stack fills with zeros and the depth ends at two.
                if (!has2)
                begin
                    ex.err = ST_UNDER;
                end
                ex.dd = has2 ? dd_reg : DW'(2);
                ex.dwe = 1'b1;
                ex.dwa = has2 ? dm2[AW-1:0] : '0;
                ex.dwd = b_v;
                ex.div = 1'b0;
            end
            OP_CALL, OP_CALLZ, OP_CALLNZ, OP_GOTO, OP_GOTOZ, OP_GOTONZ:
            begin
                ex.next = idx2;
                is_cond = !(op_reg == OP_CALL || op_reg == OP_GOTO);
                if (is_cond && !has1)
                begin
                    ex.err = ST_UNDER;
                end
                if (op_reg == OP_CALLZ || op_reg == OP_GOTOZ)
                begin
                    taken = b_v == 32'd0;
                end
                else if (op_reg == OP_CALLNZ || op_reg == OP_GOTONZ)
                begin
                    taken = b_v != 32'd0;
                end
                if (taken)
                begin
                    ex.next = imm_reg[10:0];
                    if (op_reg == OP_CALL || op_reg == OP_CALLZ || op_reg == OP_CALLNZ)
                    begin
                        if (rd_reg == DW'(STACK_DEPTH))
                        begin
                            if (ex.err == ST_OK)
                            begin
                                ex.err = ST_OVER;
                            end
                        end
                        else
                        begin
                            ex.rwe = 1'b1;
                            ex.rwa = rd_reg[AW-1:0];
                            ex.rwd = idx2;
                            ex.rd = rd_reg + DW'(1);
                        end
                    end
                end
            end
            OP_RET:
            begin
                if (rd_reg != '0)
                begin
                    ex.next = r_rdata;
                    ex.rd = rd_reg - DW'(1);
                end
                else
                begin
                    ex.err = ST_RETEMPTY;
                end
            end
            OP_HALT:
            begin
                ex.stop = 1'b1;
                ex.next = {1'b0, idx_reg};
            end
            OP_SYSEXIT:
            begin
                ex.stop = 1'b1;
                ex.next = {1'b0, idx_reg};
                ex.code = b_v;
                if (has1)
                begin
                    ex.dd = dd_reg - DW'(1);
                end
                else
                begin
                    ex.err = ST_UNDER;
                end
            end
            OP_NOP:
            begin
                ex.err = ST_OK;
            end
            default:
            begin
                ex.err = ST_UNKNOWN;
            end
        endcase
        // Stop on error: state changes still stand as the model applies them.
        if (ex.err != ST_OK && !coe_reg)
        begin
            ex.stop = 1'b1;
            ex.code = 32'd1;
            ex.next = {1'b0, idx_reg};
            ex.kind = KIND_NONE;
            ex.data = 32'd0;
            ex.div = 1'b0;
        end
    end

    // A swap also writes the old second value (zero on a short stack) into the top slot.
    logic          div_we;
    assign div_we = (state_reg == S_DIV) && div_rsp.done;

    always_comb
    begin
        d_we = 1'b0;
        d_waddr = '0;
        d_wdata = '0;
        if (state_reg == S_EXEC)
        begin
            d_we = ex.dwe;
            d_waddr = ex.dwa;
            d_wdata = ex.dwd;
        end
        else if (state_reg == S_OUT && op_reg == OP_SWAP)
        begin
            // Second write of a swap: old second value into the top slot.
            d_we = 1'b1;
            d_waddr = dm1[AW-1:0];
            d_wdata = a_reg;
        end
        else if (div_we)
        begin
            d_we = 1'b1;
            d_waddr = dm1[AW-1:0];
            d_wdata = div_rsp.quotient;
        end
    end

    assign r_we = (state_reg == S_EXEC) && ex.rwe;
    assign r_waddr = ex.rwa;
    assign r_wdata = ex.rwd;

    assign div_req.start = (state_reg == S_EXEC) && ex.div;
    assign div_req.dividend = a_v;
    assign div_req.divisor = b_v;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            dd_reg <= '0;
            rd_reg <= '0;
            halted_reg <= 1'b0;
            coe_reg <= 1'b0;
            code_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                coe_reg <= cfg_wdata;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_beat)
                    begin
                        imm_reg <= operand;
                        idx_reg <= instr_index;
                        if (halted_reg)
                        begin
                            r_next_reg <= {1'b0, instr_index};
                            r_kind_reg <= KIND_NONE;
                            r_data_reg <= '0;
                            r_status_reg <= ST_OK;
                            r_stop_reg <= 1'b1;
                            r_code_reg <= code_reg;
                            op_reg <= OP_NOP;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            op_reg <= operation;
                            state_reg <= S_RD1;
                        end
                    end
                end
                S_RD1:
                begin
                    top_reg <= d_rdata;
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    a_reg <= a_v;
                    dd_reg <= ex.dd;
                    rd_reg <= ex.rd;
                    r_next_reg <= ex.next;
                    r_kind_reg <= ex.kind;
                    r_data_reg <= ex.data;
                    r_status_reg <= ex.err;
                    r_stop_reg <= ex.stop;
                    r_code_reg <= ex.stop ? ex.code : 32'd0;
                    if (ex.stop)
                    begin
                        halted_reg <= 1'b1;
                        code_reg <= ex.code;
                    end
                    state_reg <= ex.div ? S_DIV : S_OUT;
                end
                S_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_beat)
                    begin
                        state_reg <= S_IDLE;
                        op_reg <= OP_NOP;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign next_index = r_next_reg;
    assign out_kind = r_kind_reg;
    assign out_data = r_data_reg;
    assign status = r_status_reg;
    assign stopped = r_stop_reg;
    assign exit_code = r_code_reg;

    `SMX_ASSERT_IMP(a_no_overlap, clk, rst_n, in_beat, !out_valid, "input taken while result pending")
    `SMX_ASSERT_IMP(a_dd_range, clk, rst_n, 1'b1, dd_reg <= DW'(STACK_DEPTH), "data depth out of range")
    `SMX_ASSERT_NEXT(a_halt_sticky, clk, rst_n, halted_reg, halted_reg, "halted flag dropped")
    `SMX_ASSERT_IMP(a_stop_code, clk, rst_n, out_valid && !stopped, exit_code == 32'd0, "code without stop")

endmodule
